// File: src/vkst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vkst_pkg
// Shared widths, status codes and control types of the snapshot table.
// ----------------------------------------------------------------------------
package vkst_pkg;

    localparam int KEY_W      = 64;
    localparam int SEQ_W      = 32;
    localparam int PAY_W      = 64;
    localparam int STATUS_W   = 3;
    localparam int REV_W      = 32;
    localparam int DEF_CAPACITY = 16;

    // opcodes
    localparam logic OP_UPSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STALE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // take request, run key compare, start entry read
        logic commit;   // resolve, write back, load result register
    } vkst_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_busy; // result register holds a transaction not yet taken
    } vkst_sts_t;

endpackage

// File: src/vkst_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vkst_in_if
// Request channel: opcode, key, sequence and payload with valid/ready.
// ----------------------------------------------------------------------------
interface vkst_in_if;
    import vkst_pkg::*;

    logic             valid;
    logic             ready;
    logic             opcode;
    logic [KEY_W-1:0] key;
    logic [SEQ_W-1:0] sequence_req;
    logic [PAY_W-1:0] payload;

    modport source (output valid, input ready, output opcode, output key,
                    output sequence_req, output payload);
    modport sink   (input valid, output ready, input opcode, input key,
                    input sequence_req, input payload);
endinterface

// File: src/vkst_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vkst_out_if
// Result channel: status, found entry and revision with valid/ready.
// ----------------------------------------------------------------------------
interface vkst_out_if;
    import vkst_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SEQ_W-1:0]    found_sequence;
    logic [PAY_W-1:0]    found_payload;
    logic [REV_W-1:0]    revision_out;

    modport source (output valid, input ready, output status,
                    output found_sequence, output found_payload,
                    output revision_out);
    modport sink   (input valid, output ready, input status,
                    input found_sequence, input found_payload,
                    input revision_out);
endinterface

// File: src/vkst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vkst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vkst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/vkst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vkst_ctrl
// Two-state sequencer: capture a request, then commit once the result
// register is free.
// ----------------------------------------------------------------------------
module vkst_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  vkst_pkg::vkst_sts_t sts,
    output vkst_pkg::vkst_cmd_t cmd
);
    import vkst_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_BUSY = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next  = state_reg;
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_BUSY;
                end
            end
            S_BUSY:
            begin
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/vkst_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vkst_datapath
// Key store with parallel compare, entry RAM, revision counter and the
// result register.
// ----------------------------------------------------------------------------
module vkst_datapath #(
    parameter int CAPACITY = vkst_pkg::DEF_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vkst_pkg::vkst_cmd_t           cmd,
    output vkst_pkg::vkst_sts_t           sts,
    input  logic                          req_opcode,
    input  logic [vkst_pkg::KEY_W-1:0]    req_key,
    input  logic [vkst_pkg::SEQ_W-1:0]    req_sequence,
    input  logic [vkst_pkg::PAY_W-1:0]    req_payload,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [vkst_pkg::STATUS_W-1:0] out_status,
    output logic [vkst_pkg::SEQ_W-1:0]    out_found_sequence,
    output logic [vkst_pkg::PAY_W-1:0]    out_found_payload,
    output logic [vkst_pkg::REV_W-1:0]    out_revision
);
    import vkst_pkg::*;

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int UW    = $clog2(CAPACITY + 1);
    localparam int ENT_W = SEQ_W + PAY_W;

    // key store: written at one slot, each entry compared in place
    logic [KEY_W-1:0] key_arr_reg [CAPACITY];
    logic [UW-1:0]    used_reg;
    logic [REV_W-1:0] revision_reg;

    // captured request
    logic             op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [SEQ_W-1:0] seq_reg;
    logic [PAY_W-1:0] pay_reg;
    logic             hit_reg;
    logic [AW-1:0]    slot_reg;

    // result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SEQ_W-1:0]    fseq_reg;
    logic [PAY_W-1:0]    fpay_reg;

    logic [CAPACITY-1:0] match;
    logic                hit;
    logic [AW-1:0]       slot_enc;
    logic [ENT_W-1:0]    ent_rdata;
    logic [SEQ_W-1:0]    ent_seq;
    logic [PAY_W-1:0]    ent_pay;

    logic                wr_any;
    logic [STATUS_W-1:0] status_val;
    logic [SEQ_W-1:0]    fseq_val;
    logic [PAY_W-1:0]    fpay_val;
    logic                wr_upd;
    logic                wr_app;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;

    // keys are unique among live entries, so an OR encode picks the slot
    always_comb
    begin
        slot_enc = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            match[i] = (UW'(i) < used_reg) && (key_arr_reg[i] == req_key);
            if (match[i])
            begin
                slot_enc = slot_enc | AW'(i);
            end
        end
        hit = |match;
    end

    vkst_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ent_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({seq_reg, pay_reg}),
        .re    (cmd.capture),
        .raddr (slot_enc),
        .rdata (ent_rdata)
    );

    assign ent_seq = ent_rdata[ENT_W-1:PAY_W];
    assign ent_pay = ent_rdata[PAY_W-1:0];

    // resolve the captured request
    always_comb
    begin
        status_val = ST_OK;
        fseq_val   = '0;
        fpay_val   = '0;
        wr_upd     = 1'b0;
        wr_app     = 1'b0;
        wr_any     = 1'b0;
        if (op_reg == OP_FIND)
        begin
            if (hit_reg)
            begin
                fseq_val = ent_seq;
                fpay_val = ent_pay;
            end
            else
            begin
                status_val = ST_NOT_FOUND;
            end
        end
        else if (key_reg == '0)
        begin
            status_val = ST_INVALID;
        end
        else if (hit_reg)
        begin
            if (seq_reg < ent_seq)
            begin
                status_val = ST_STALE;
            end
            else
            begin
                wr_upd = 1'b1;
            end
        end
        else if (used_reg >= UW'(CAPACITY))
        begin
            status_val = ST_FULL;
        end
        else
        begin
            wr_app = 1'b1;
        end
        wr_any = wr_upd | wr_app;
    end

    assign ram_we    = cmd.commit && wr_any;
    assign ram_waddr = wr_upd ? slot_reg : used_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= req_opcode;
            key_reg  <= req_key;
            seq_reg  <= req_sequence;
            pay_reg  <= req_payload;
            hit_reg  <= hit;
            slot_reg <= slot_enc;
        end
        if (cmd.commit && wr_app)
        begin
            key_arr_reg[used_reg[AW-1:0]] <= key_reg;
        end
        if (cmd.commit)
        begin
            status_reg <= status_val;
            fseq_reg   <= fseq_val;
            fpay_reg   <= fpay_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            revision_reg  <= REV_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit && wr_app)
            begin
                used_reg <= used_reg + UW'(1);
            end
            if (cmd.commit && wr_any)
            begin
                revision_reg <= revision_reg + REV_W'(1);
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_busy       = out_valid_reg && !out_ready;
    assign out_valid          = out_valid_reg;
    assign out_status         = status_reg;
    assign out_found_sequence = fseq_reg;
    assign out_found_payload  = fpay_reg;
    assign out_revision       = revision_reg;

    // fill count never passes the table size
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(CAPACITY))
        else $error("entry count beyond capacity");

    // a committed write moves the revision by exactly one
    a_rev_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && wr_any) |=>
            (revision_reg == $past(revision_reg) + REV_W'(1)))
        else $error("revision did not advance on write");

    // a refused or read-only transaction leaves the revision alone
    a_rev_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !wr_any) |=> $stable(revision_reg))
        else $error("revision moved without a write");

    // found fields are zero unless the status is ok
    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |->
            (fseq_reg == '0 && fpay_reg == '0))
        else $error("found fields set on failed transaction");

    // the result register is never overwritten while it still waits
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten before taken");

endmodule

// File: src/versioned_keyed_snapshot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// versioned_keyed_snapshot_table
// Keyed table of (sequence, payload) snapshots with monotonic-sequence upsert,
// find by key and a wrapping revision counter.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | carries
//  --------+-----+--------------+---------------------------------------------
//  req     | in  | valid/ready  | opcode, key, sequence_req, payload
//  rsp     | out | valid/ready  | status, found_sequence, found_payload,
//          |     |              | revision_out
//
//  Each transaction runs as a capture step and a commit step: capture accepts
//  it, compares the key against all live keys in parallel and starts the
//  registered entry RAM read; commit resolves status and writes back.
//  Reset clears the fill count, sets the revision to 1 and empties the
//  result register; entry contents need no clearing (only live slots are
//  compared or read). A stalled rsp holds the commit step; req stays low
//  ready until the result register is free to take the next result.
// ----------------------------------------------------------------------------
module versioned_keyed_snapshot_table #(
    parameter int CAPACITY = vkst_pkg::DEF_CAPACITY
) (
    input  logic       clk,
    input  logic       rst_n,
    vkst_in_if.sink    req,
    vkst_out_if.source rsp
);
    import vkst_pkg::*;

    vkst_cmd_t cmd;
    vkst_sts_t sts;

    // sequencer: capture, then commit when the result slot is free
    vkst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // key compare, entry RAM, revision and result register
    vkst_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .req_opcode         (req.opcode),
        .req_key            (req.key),
        .req_sequence       (req.sequence_req),
        .req_payload        (req.payload),
        .out_valid          (rsp.valid),
        .out_ready          (rsp.ready),
        .out_status         (rsp.status),
        .out_found_sequence (rsp.found_sequence),
        .out_found_payload  (rsp.found_payload),
        .out_revision       (rsp.revision_out)
    );

endmodule
